>>> design/vmrr_pkg.sv
// Shared constants for the von Mises radial return block.
// No dependencies; every other design file imports this package.
package vmrr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int REG_YIELD_STRESS = 0;

endpackage

>>> design/vmrr_energy.sv
// Front pipeline: magnitudes, squares, von Mises sum and the yield test.
// Five register stages. Depends on vmrr_pkg.
module vmrr_energy
    import vmrr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [DATA_WIDTH-1:0]       i_sx,
    input  logic [DATA_WIDTH-1:0]       i_sy,
    input  logic [DATA_WIDTH-1:0]       i_txy,
    input  logic [DATA_WIDTH-2:0]       i_yield,
    output logic                        o_valid,
    output logic [2*DATA_WIDTH+1:0]     o_v,
    output logic                        o_inside,
    output logic [3*DATA_WIDTH-1:0]     o_side
);

    localparam int DW = DATA_WIDTH;
    localparam int VW = 2 * DW + 2;
    localparam int NS = 5;

    logic [NS-1:0]   r_valid;
    logic [3*DW-1:0] r_side [0:NS-1];

    logic [DW-1:0]   r_ax, r_ay, r_ad, r_at;
    logic [2*DW-1:0] r_a2, r_b2, r_d2, r_t2;
    logic [2*DW-3:0] r_lim_b, r_lim_c, r_lim_d;
    logic [VW-1:0]   r_s3, r_t3, r_v_d, r_v_e;
    logic            r_inside;

    logic [DW:0]     n_diff;
    logic [DW-1:0]   n_ax, n_ay, n_ad, n_at;

    always_comb begin
        n_diff = {i_sx[DW-1], i_sx} - {i_sy[DW-1], i_sy};
        n_ax   = i_sx[DW-1] ? (~i_sx + 1'b1) : i_sx;
        n_ay   = i_sy[DW-1] ? (~i_sy + 1'b1) : i_sy;
        n_at   = i_txy[DW-1] ? (~i_txy + 1'b1) : i_txy;
        n_ad   = n_diff[DW] ? DW'(~n_diff + 1'b1) : n_diff[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= {i_sx, i_sy, i_txy};
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_ax     <= n_ax;
            r_ay     <= n_ay;
            r_ad     <= n_ad;
            r_at     <= n_at;
            r_a2     <= r_ax * r_ax;
            r_b2     <= r_ay * r_ay;
            r_d2     <= r_ad * r_ad;
            r_t2     <= r_at * r_at;
            r_lim_b  <= i_yield * i_yield;
            r_s3     <= VW'(r_a2) + VW'(r_b2) + VW'(r_d2);
            r_t3     <= VW'(r_t2) + VW'({r_t2, 1'b0});
            r_lim_c  <= r_lim_b;
            r_v_d    <= (r_s3 >> 1) + r_t3;
            r_lim_d  <= r_lim_c;
            r_v_e    <= r_v_d;
            r_inside <= r_v_d <= VW'(r_lim_d);
        end
    end

    assign o_valid  = r_valid[NS-1];
    assign o_v      = r_v_e;
    assign o_inside = r_inside;
    assign o_side   = r_side[NS-1];

endmodule

>>> design/vmrr_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Carries a sideband word alongside. Depends on vmrr_pkg.
module vmrr_sqrt
    import vmrr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int SIDE_WIDTH = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2*DATA_WIDTH+1:0] i_v,
    input  logic [SIDE_WIDTH-1:0]   i_side,
    output logic                    o_valid,
    output logic [DATA_WIDTH:0]     o_root,
    output logic [SIDE_WIDTH-1:0]   o_side
);

    localparam int DW = DATA_WIDTH;
    localparam int VW = 2 * DW + 2;
    localparam int RW = DW + 4;
    localparam int NS = DW + 1;

    logic [NS-1:0]         r_valid;
    logic [RW-1:0]         r_rem  [0:NS-1];
    logic [DW:0]           r_root [0:NS-1];
    logic [VW-1:0]         r_rad  [0:NS-1];
    logic [SIDE_WIDTH-1:0] r_side [0:NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [RW-1:0] w_rem_in;
        logic [DW:0]   w_root_in;
        logic [VW-1:0] w_rad_in;
        logic [RW-1:0] w_cur;
        logic [RW-1:0] w_trial;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_v;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
        end

        assign w_cur   = {w_rem_in[RW-3:0], w_rad_in[VW-1:VW-2]};
        assign w_trial = {{(RW-DW-3){1'b0}}, w_root_in, 2'b01};
        assign w_ge    = w_cur >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? (w_cur - w_trial) : w_cur;
                r_root[k] <= {w_root_in[DW-1:0], w_ge};
                r_rad[k]  <= {w_rad_in[VW-3:0], 2'b00};
                r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

>>> design/vmrr_div.sv
// Three-lane pipelined restoring divider with a shared divisor,
// one quotient bit per register stage. Depends on vmrr_pkg.
module vmrr_div
    import vmrr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int SIDE_WIDTH = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2*DATA_WIDTH-1:0] i_num [0:2],
    input  logic [DATA_WIDTH:0]     i_den,
    input  logic [SIDE_WIDTH-1:0]   i_side,
    output logic                    o_valid,
    output logic [DATA_WIDTH-1:0]   o_quo [0:2],
    output logic [SIDE_WIDTH-1:0]   o_side
);

    localparam int DW  = DATA_WIDTH;
    localparam int RDW = DW + 2;
    localparam int NS  = DW;

    logic [NS-1:0]         r_valid;
    logic [DW:0]           r_den  [0:NS-1];
    logic [SIDE_WIDTH-1:0] r_side [0:NS-1];
    logic [RDW-1:0]        r_rem  [0:NS-1][0:2];
    logic [DW-1:0]         r_low  [0:NS-1][0:2];
    logic [DW-1:0]         r_quo  [0:NS-1][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [DW:0]           w_den_in;
        logic [SIDE_WIDTH-1:0] w_side_in;

        if (k == 0) begin : g_first
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_den_in  = r_den[k-1];
            assign w_side_in = r_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= w_den_in;
                r_side[k] <= w_side_in;
            end
        end

        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic [RDW-1:0] w_rem_in;
            logic [DW-1:0]  w_low_in;
            logic [DW-1:0]  w_quo_in;
            logic [RDW-1:0] w_cur;
            logic           w_ge;

            if (k == 0) begin : g_first
                assign w_rem_in = {2'b00, i_num[j][2*DW-1:DW]};
                assign w_low_in = i_num[j][DW-1:0];
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1][j];
                assign w_low_in = r_low[k-1][j];
                assign w_quo_in = r_quo[k-1][j];
            end

            assign w_cur = {w_rem_in[RDW-2:0], w_low_in[DW-1]};
            assign w_ge  = w_cur >= {1'b0, w_den_in};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k][j] <= w_ge ? (w_cur - {1'b0, w_den_in}) : w_cur;
                    r_low[k][j] <= {w_low_in[DW-2:0], 1'b0};
                    r_quo[k][j] <= {w_quo_in[DW-2:0], w_ge};
                end
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_side  = r_side[NS-1];
    for (genvar j = 0; j < 3; j++) begin : g_out
        assign o_quo[j] = r_quo[NS-1][j];
    end

endmodule

>>> design/von_mises_radial_return_2d.sv
// Von Mises radial return of plane stress states, one word per cycle.
// The pipeline holds five front stages, DATA_WIDTH+1 square root stages, one
// scaling multiply stage, DATA_WIDTH divider stages and the output register;
// the whole pipeline advances together whenever the output register is empty
// or being taken, so a new word is accepted on every such cycle.
// Depends on vmrr_pkg, vmrr_energy, vmrr_sqrt and vmrr_div.
module von_mises_radial_return_2d
    import vmrr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [((DATA_WIDTH > 33) ? 4 : 3)-1:0] paddr,
    input  logic [((DATA_WIDTH > 33) ? 64 : 32)-1:0] pwdata,
    output logic [((DATA_WIDTH > 33) ? 64 : 32)-1:0] prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [DATA_WIDTH-1:0]   i_stress_xx,
    input  logic [DATA_WIDTH-1:0]   i_stress_yy,
    input  logic [DATA_WIDTH-1:0]   i_shear_xy,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [DATA_WIDTH-1:0]   o_out_xx,
    output logic [DATA_WIDTH-1:0]   o_out_yy,
    output logic [DATA_WIDTH-1:0]   o_out_shear,
    output logic [DATA_WIDTH:0]     o_equivalent_stress,
    output logic                    o_inside_yield
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = (DW > 33) ? 64 : 32;
    localparam int AW = (DW > 33) ? 4 : 3;
    localparam int SQ_SIDE = 3 * DW + 1;
    localparam int DV_SIDE = 3 * DW + DW + 2;

    logic          w_en;
    logic [DW-2:0] r_yield;

    assign pready = 1'b1;
    assign prdata = PW'(r_yield);
    assign w_en   = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yield <= (DW-1)'(1) << FRAC_BITS;
        end else if (psel && penable && pwrite && pready
                     && paddr[AW-1:2] == (AW-2)'(REG_YIELD_STRESS)) begin
            r_yield <= pwdata[DW-2:0];
        end
    end

    logic                   w_e_valid, w_e_inside;
    logic [2*DW+1:0]        w_e_v;
    logic [3*DW-1:0]        w_e_side;

    vmrr_energy #(.DATA_WIDTH(DW)) u_energy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_sx     (i_stress_xx),
        .i_sy     (i_stress_yy),
        .i_txy    (i_shear_xy),
        .i_yield  (r_yield),
        .o_valid  (w_e_valid),
        .o_v      (w_e_v),
        .o_inside (w_e_inside),
        .o_side   (w_e_side)
    );

    logic               w_s_valid;
    logic [DW:0]        w_s_root;
    logic [SQ_SIDE-1:0] w_s_side;

    vmrr_sqrt #(.DATA_WIDTH(DW), .SIDE_WIDTH(SQ_SIDE)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_e_valid),
        .i_v     (w_e_v),
        .i_side  ({w_e_inside, w_e_side}),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    logic [DW-1:0]      w_mag [0:2];
    logic               r_p_valid;
    logic [2*DW-1:0]    r_p_num [0:2];
    logic [DW:0]        r_p_q;
    logic [SQ_SIDE-1:0] r_p_side;

    for (genvar j = 0; j < 3; j++) begin : g_mag
        logic [DW-1:0] w_s;
        assign w_s      = w_s_side[(3-j)*DW-1 -: DW];
        assign w_mag[j] = w_s[DW-1] ? (~w_s + 1'b1) : w_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_p_num[j] <= (2*DW)'(w_mag[j] * r_yield);
            end
            r_p_q    <= w_s_root;
            r_p_side <= w_s_side;
        end
    end

    logic               w_d_valid;
    logic [DW-1:0]      w_d_quo [0:2];
    logic [DV_SIDE-1:0] w_d_side;

    vmrr_div #(.DATA_WIDTH(DW), .SIDE_WIDTH(DV_SIDE)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_valid),
        .i_num   (r_p_num),
        .i_den   (r_p_q),
        .i_side  ({r_p_q, r_p_side}),
        .o_valid (w_d_valid),
        .o_quo   (w_d_quo),
        .o_side  (w_d_side)
    );

    logic          w_inside;
    logic [DW-1:0] w_res [0:2];

    assign w_inside = w_d_side[3*DW];
    for (genvar j = 0; j < 3; j++) begin : g_res
        logic [DW-1:0] w_s;
        assign w_s      = w_d_side[(3-j)*DW-1 -: DW];
        assign w_res[j] = w_inside ? w_s
                        : (w_s[DW-1] ? (~w_d_quo[j] + 1'b1) : w_d_quo[j]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out_xx            <= w_res[0];
            o_out_yy            <= w_res[1];
            o_out_shear         <= w_res[2];
            o_equivalent_stress <= w_d_side[DV_SIDE-1 -: DW+1];
            o_inside_yield      <= w_inside;
        end
    end

    a_inside_within: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inside_yield) |-> (o_equivalent_stress <= (DW+1)'(r_yield)))
        else $error("inside word has equivalent stress above yield");

    a_projected_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inside_yield) |->
            (o_equivalent_stress >= (DW+1)'(r_yield) && o_equivalent_stress != '0))
        else $error("projected word has equivalent stress below yield");

    a_ready_follows_output: assert property (@(posedge i_clk)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for von_mises_radial_return_2d: random and corner stress states
// are pushed through the valid/ready stream while a behavioral projection predicts results.
// Depends on vmrr_pkg and the von_mises_radial_return_2d RTL.
`timescale 1ns / 1ps

module tb_top;
    import vmrr_pkg::*;

    localparam int DW = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PIPE_DEPTH = 2 * DW + 8;

    typedef struct packed {
        logic [DW-1:0] sxx;
        logic [DW-1:0] syy;
        logic [DW-1:0] txy;
    } t_stress;

    typedef struct packed {
        logic [DW-1:0] xx;
        logic [DW-1:0] yy;
        logic [DW-1:0] sh;
        logic [DW:0]   q;
        logic          in_yield;
    } t_proj;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [DW-1:0] i_stress_xx = '0, i_stress_yy = '0, i_shear_xy = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [DW-1:0] o_out_xx, o_out_yy, o_out_shear;
    logic [DW:0] o_equivalent_stress;
    logic o_inside_yield;

    von_mises_radial_return_2d uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_stress pending_states[$];
    t_proj expected_proj[$];
    logic [30:0] yield_model = 31'd65536;
    int errors = 0;
    int idle_cycles = 0;
    bit in_taken = 1'b0;
    bit hold_sender = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;

    function automatic logic [63:0] mag32(logic [DW-1:0] s);
        return s[DW-1] ? 64'(-$signed({{32{s[DW-1]}}, s})) : 64'(s);
    endfunction

    function automatic logic [65:0] isqrt(logic [127:0] v);
        logic [65:0] r;
        logic [65:0] c;
        r = '0;
        for (int b = DW + 1; b >= 0; b--) begin
            c = r | (66'd1 << b);
            if ({62'd0, c} * {62'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] scale_onto_surface(logic [DW-1:0] s, logic [65:0] q);
        logic [127:0] prod;
        logic [127:0] mag;
        prod = {64'd0, mag32(s)} * {97'd0, yield_model};
        mag = prod / {62'd0, q};
        return s[DW-1] ? DW'(-mag) : DW'(mag);
    endfunction

    function automatic t_proj project_stress(t_stress st);
        t_proj r;
        logic signed [63:0] sx, sy, txy;
        logic [127:0] a, b, d, t, v, lim;
        logic [65:0] q;
        sx = $signed(st.sxx);
        sy = $signed(st.syy);
        txy = $signed(st.txy);
        a = sx < 0 ? -sx : sx;
        b = sy < 0 ? -sy : sy;
        d = (sx - sy) < 0 ? -(sx - sy) : (sx - sy);
        t = txy < 0 ? -txy : txy;
        v = ((a * a + b * b + d * d) >> 1) + 3 * t * t;
        q = isqrt(v);
        lim = {97'd0, yield_model} * {97'd0, yield_model};
        r.q = q[DW:0];
        if (v <= lim) begin
            r.xx = st.sxx;
            r.yy = st.syy;
            r.sh = st.txy;
            r.in_yield = 1'b1;
        end else begin
            r.xx = scale_onto_surface(st.sxx, q);
            r.yy = scale_onto_surface(st.syy, q);
            r.sh = scale_onto_surface(st.txy, q);
            r.in_yield = 1'b0;
        end
        return r;
    endfunction

    task automatic write_yield(logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_YIELD_STRESS);
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        yield_model = value[30:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_states.size() != 0 || expected_proj.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return 32'($signed($urandom_range(0, 512 << 16)) - (256 << 16));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(int n);
        t_stress st;
        for (int k = 0; k < n; k++) begin
            st.sxx = rand_field();
            st.syy = rand_field();
            st.txy = rand_field();
            pending_states.push_back(st);
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_states.size() != 0 && !hold_sender) begin
                    i_valid <= 1'b1;
                    {i_stress_xx, i_stress_yy, i_shear_xy} <= pending_states[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
            stall_phase <= (stall_phase + 1) % 64;
            i_ready <= (stall_phase < 20) ? 1'b1 : (stall_phase < 40)
                ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge i_clk) begin
        t_proj want;
        if (i_rst_n) begin
            in_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                expected_proj.push_back(project_stress(
                    {i_stress_xx, i_stress_yy, i_shear_xy}));
                void'(pending_states.pop_front());
            end
            if (o_valid && i_ready) begin
                if (expected_proj.size() == 0) begin
                    $error("Unexpected output word");
                    errors++;
                end else begin
                    want = expected_proj.pop_front();
                    if (o_out_xx !== want.xx) begin
                        $error("out_xx: expected %h, got %h", want.xx, o_out_xx);
                        errors++;
                    end
                    if (o_out_yy !== want.yy) begin
                        $error("out_yy: expected %h, got %h", want.yy, o_out_yy);
                        errors++;
                    end
                    if (o_out_shear !== want.sh) begin
                        $error("out_shear: expected %h, got %h", want.sh, o_out_shear);
                        errors++;
                    end
                    if (o_equivalent_stress !== want.q) begin
                        $error("equivalent_stress: expected %h, got %h",
                            want.q, o_equivalent_stress);
                        errors++;
                    end
                    if (o_inside_yield !== want.in_yield) begin
                        $error("inside_yield: expected %b, got %b",
                            want.in_yield, o_inside_yield);
                        errors++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_stress st;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        st = '{32'h0, 32'h0, 32'h0};                   pending_states.push_back(st);
        st = '{32'h0001_0000, 32'h0, 32'h0};           pending_states.push_back(st);
        st = '{32'h0000_8000, 32'h0000_8000, 32'h0};   pending_states.push_back(st);
        st = '{32'h0002_0000, 32'hfffe_0000, 32'h0};   pending_states.push_back(st);
        st = '{32'h0, 32'h0, 32'h0001_0000};           pending_states.push_back(st);
        st = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; pending_states.push_back(st);
        st = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}; pending_states.push_back(st);
        st = '{32'h8000_0000, 32'h7fff_ffff, 32'h0};   pending_states.push_back(st);
        st = '{32'h0, 32'h8000_0000, 32'h8000_0000};   pending_states.push_back(st);
        st = '{32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff}; pending_states.push_back(st);
        st = '{32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333}; pending_states.push_back(st);
        queue_random(30);
        wait_drained();

        write_yield(32'h0);
        st = '{32'h0, 32'h0, 32'h0};                   pending_states.push_back(st);
        st = '{32'h0000_0001, 32'h0, 32'h0};           pending_states.push_back(st);
        st = '{32'h8000_0000, 32'h1234_5678, 32'hffff_fff0}; pending_states.push_back(st);
        queue_random(40);
        wait_drained();

        write_yield(32'hffff_ffff);
        st = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; pending_states.push_back(st);
        st = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}; pending_states.push_back(st);
        queue_random(80);
        wait_drained();

        write_yield(32'h0010_0000);
        queue_random(100);
        while (pending_states.size() > 50) @(posedge i_clk);
        hold_sender = 1'b1;
        while (expected_proj.size() != 0) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drained();

        write_yield(32'h0000_0001);
        queue_random(60);
        wait_drained();

        write_yield($urandom);
        queue_random(130);
        wait_drained();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
